// ===== rtl/core/capability_bounds_decode_check_assert.svh =====
// Assertion macros for the capability bounds decode and check block.
`ifndef CAPABILITY_BOUNDS_DECODE_CHECK_ASSERT_SVH
`define CAPABILITY_BOUNDS_DECODE_CHECK_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("capability check assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CBDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("capability check assertion failed");

`endif

// ===== rtl/core/cbdc_pkg.sv =====
// Shared types and constants for the capability bounds decode and check block.
package cbdc_pkg;

    localparam logic [63:0] NULL_MASK = 64'h0000_1fff_fc01_8004;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    localparam int unsigned PERM_READ  = 1;
    localparam int unsigned PERM_WRITE = 0;

    typedef struct packed {
        logic [31:0] base_off;
        logic [31:0] top_off;
        logic [1:0]  perm;
    } dec_res_t;

endpackage

// ===== rtl/core/cbdc_decode.sv =====
// Two-stage decoder from compressed capability metadata to base and top offsets.
module cbdc_decode (
    input  logic              clk,
    input  logic              load,
    input  logic [63:0]       meta_word,
    input  logic [63:0]       address,
    output cbdc_pkg::dec_res_t res
);
    import cbdc_pkg::*;

    function automatic logic [31:0] region_adj(
        input logic [31:0] a_top,
        input logic [2:0]  a3,
        input logic [2:0]  x3,
        input logic [2:0]  r
    );
        logic a_lo;
        logic x_lo;
        logic [31:0] adj;
        a_lo = (a3 < r);
        x_lo = (x3 < r);
        case ({a_lo, x_lo})
            2'b10:   adj = a_top - 32'd1;
            2'b01:   adj = a_top + 32'd1;
            default: adj = a_top;
        endcase
        return adj;
    endfunction

    logic [63:0] cap;
    logic        ie;
    logic [8:0]  t_hi;
    logic [2:0]  t_e;
    logic [10:0] b_hi;
    logic [2:0]  b_e;
    logic [5:0]  e;
    logic [11:0] tm12;
    logic [13:0] bm;
    logic        carry;
    logic [1:0]  t_top2;
    logic [13:0] tm;
    logic [63:0] sh;
    logic [2:0]  a3;
    logic [31:0] a_top;
    logic [2:0]  r;

    logic [5:0]  e_reg;
    logic [13:0] tm_reg;
    logic [13:0] bm_reg;
    logic [31:0] top_hi_reg;
    logic [31:0] base_hi_reg;
    logic [31:0] addr_lo_reg;
    logic [1:0]  perm_reg;

    logic [6:0]  hi_sh;
    logic [31:0] top_full;
    logic [31:0] base_full;

    always_comb
    begin
        cap    = meta_word ^ NULL_MASK;
        ie     = cap[26];
        t_hi   = cap[25:17];
        t_e    = cap[16:14];
        b_hi   = cap[13:3];
        b_e    = cap[2:0];
        e      = ie ? {t_e, b_e} : 6'd0;
        tm12   = ie ? {t_hi, 3'b000} : {t_hi, t_e};
        bm     = ie ? {b_hi, 3'b000} : {b_hi, b_e};
        carry  = (tm12 < bm[11:0]);
        t_top2 = bm[13:12] + {1'b0, carry} + {1'b0, ie};
        tm     = {t_top2, tm12};
        sh     = address >> (7'(e) + 7'd11);
        a3     = sh[2:0];
        a_top  = sh[34:3];
        r      = bm[13:11] - 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            e_reg       <= e;
            tm_reg      <= tm;
            bm_reg      <= bm;
            top_hi_reg  <= region_adj(a_top, a3, tm[13:11], r);
            base_hi_reg <= region_adj(a_top, a3, bm[13:11], r);
            addr_lo_reg <= address[31:0];
            perm_reg    <= {cap[61], cap[60]};
        end
    end

    always_comb
    begin
        hi_sh     = 7'(e_reg) + 7'd14;
        top_full  = (top_hi_reg << hi_sh) | (32'(tm_reg) << e_reg);
        base_full = (base_hi_reg << hi_sh) | (32'(bm_reg) << e_reg);
        res.base_off = base_full - addr_lo_reg;
        res.top_off  = top_full - addr_lo_reg;
        res.perm     = perm_reg;
    end

endmodule

// ===== rtl/core/capability_bounds_decode_check.sv =====
// Capability bounds decoder and access checker with an on-chip slot table.
// The result strobe (done) is registered from the ST_EXEC state after the start is accepted in ST_IDLE.
// A new item is accepted only in ST_IDLE; busy is high while the block is in ST_EXEC.
// Reset: asynchronous active-low; clears control and the sticky fault flag.
// The slot table is not cleared; done is a one-cycle strobe, result outputs hold until the next result.
`include "capability_bounds_decode_check_assert.svh"

module capability_bounds_decode_check #(
    parameter int unsigned CAP_SLOTS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic [2:0]         slot,
    input  logic [63:0]        meta_word,
    input  logic [63:0]        address,
    input  logic [15:0]        word_offset,
    input  logic [2:0]         access_bytes,
    input  logic               is_write,
    output logic               done,
    output logic signed [31:0] base_offset,
    output logic signed [31:0] top_offset,
    output logic               can_read,
    output logic               can_write,
    output logic               allowed,
    output logic               fault_flag
);
    import cbdc_pkg::*;

    localparam int unsigned IDX_W = (CAP_SLOTS > 1) ? $clog2(CAP_SLOTS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic             accept;
    logic [IDX_W+2:0] slot_ext;
    logic [IDX_W-1:0] slot_idx;
    logic             slot_ok;

    logic             kind_reg;
    logic             slot_ok_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [15:0]      off_reg;
    logic [2:0]       bytes_reg;
    logic             wr_reg;

    dec_res_t         slot_mem [CAP_SLOTS];
    dec_res_t         rd_data_reg;
    dec_res_t         dec_res;
    logic             mem_we;

    logic [17:0]      lo;
    logic [18:0]      hi;
    logic             base_ok;
    logic             top_ok;
    logic             perm_ok;
    logic             chk_allowed;
    dec_res_t         res_sel;
    logic             allowed_sel;

    logic             done_reg, done_next;
    logic             sticky_reg, sticky_next;
    logic [31:0]      base_offset_reg;
    logic [31:0]      top_offset_reg;
    logic [1:0]       perm_out_reg;
    logic             allowed_reg;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign slot_ext = {{IDX_W{1'b0}}, slot};
    assign slot_idx = slot_ext[IDX_W-1:0];
    assign slot_ok  = (32'(slot) < CAP_SLOTS);

    cbdc_decode u_decode (
        .clk       (clk),
        .load      (accept),
        .meta_word (meta_word),
        .address   (address),
        .res       (dec_res)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind;
            slot_ok_reg <= slot_ok;
            idx_reg     <= slot_idx;
            off_reg     <= word_offset;
            bytes_reg   <= access_bytes;
            wr_reg      <= is_write;
        end
    end

    // Write back a decoded slot; read the addressed slot on accept.
    assign mem_we = (state_reg == ST_EXEC) && (kind_reg == KIND_LOAD) && slot_ok_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[idx_reg] <= dec_res;
        end
        if (accept)
        begin
            rd_data_reg <= slot_mem[slot_idx];
        end
    end

    always_comb
    begin
        lo          = {off_reg, 2'b00};
        hi          = {1'b0, lo} + {16'd0, bytes_reg};
        base_ok     = ($signed(rd_data_reg.base_off) <= $signed({14'd0, lo}));
        top_ok      = ($signed({13'd0, hi}) <= $signed(rd_data_reg.top_off));
        perm_ok     = wr_reg ? rd_data_reg.perm[PERM_WRITE] : rd_data_reg.perm[PERM_READ];
        chk_allowed = slot_ok_reg && base_ok && top_ok && perm_ok;
        res_sel     = '0;
        allowed_sel = 1'b0;
        case (kind_reg)
            KIND_LOAD:
            begin
                res_sel = dec_res;
            end
            KIND_CHECK:
            begin
                if (slot_ok_reg)
                begin
                    res_sel = rd_data_reg;
                end
                allowed_sel = chk_allowed;
            end
            default:
            begin
                res_sel = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        sticky_next = sticky_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if ((kind_reg == KIND_CHECK) && !chk_allowed)
                begin
                    sticky_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            sticky_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            sticky_reg <= sticky_next;
        end
    end

    // Hold the result beat for its strobe cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            base_offset_reg <= res_sel.base_off;
            top_offset_reg  <= res_sel.top_off;
            perm_out_reg    <= res_sel.perm;
            allowed_reg     <= allowed_sel;
        end
    end

    assign done        = done_reg;
    assign base_offset = $signed(base_offset_reg);
    assign top_offset  = $signed(top_offset_reg);
    assign can_read    = perm_out_reg[PERM_READ];
    assign can_write   = perm_out_reg[PERM_WRITE];
    assign allowed     = allowed_reg;
    assign fault_flag  = sticky_reg;

    `CBDC_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    `CBDC_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    `CBDC_ASSERT_NXT(a_fault_sticky, clk, rst_n, fault_flag, fault_flag)
    `CBDC_ASSERT_IMP(a_allowed_perm, clk, rst_n, done && allowed, can_read || can_write)
    `CBDC_ASSERT_IMP(a_refused_fault, clk, rst_n, done && (kind_reg == KIND_CHECK) && !allowed, fault_flag)

endmodule

// ===== dv/capability_bounds_decode_check_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the capability decoder: predicts every accepted beat and compares on done.
module capability_bounds_decode_check_checker #(
    parameter int unsigned CAP_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        kind,
    input  logic [2:0]  slot,
    input  logic [63:0] meta_word,
    input  logic [63:0] address,
    input  logic [15:0] word_offset,
    input  logic [2:0]  access_bytes,
    input  logic        is_write,
    input  logic        done,
    input  logic [31:0] base_offset,
    input  logic [31:0] top_offset,
    input  logic        can_read,
    input  logic        can_write,
    input  logic        allowed,
    input  logic        fault_flag,
    output int          mismatches,
    output int          outstanding,
    output int          results_checked
);
    import cbdc_pkg::*;

    typedef struct packed {
        logic [31:0] base_off;
        logic [31:0] top_off;
        logic        rd;
        logic        wr;
        logic        ok;
        logic        fault;
    } access_verdict_t;

    access_verdict_t verdict_q[$];
    dec_res_t        cap_table [0:7];
    logic            sticky_fault;

    function automatic logic [63:0] shr64(input logic [63:0] v, input int unsigned s);
        return (s >= 64) ? 64'd0 : (v >> s);
    endfunction

    function automatic logic [31:0] shl32(input logic [31:0] v, input int unsigned s);
        return (s >= 32) ? 32'd0 : (v << s);
    endfunction

    function automatic int region_shift(input logic [2:0] a3, input logic [2:0] x3,
                                        input logic [2:0] r);
        logic a_lo;
        logic x_lo;
        a_lo = a3 < r;
        x_lo = x3 < r;
        if (a_lo && !x_lo)
            return -1;
        if (!a_lo && x_lo)
            return 1;
        return 0;
    endfunction

    function automatic dec_res_t decode_cap(input logic [63:0] meta, input logic [63:0] addr);
        logic [63:0] c;
        logic        ie;
        logic [5:0]  e;
        logic [13:0] tm;
        logic [13:0] bm;
        logic        carry;
        logic [1:0]  top2;
        logic [2:0]  a3;
        logic [2:0]  r;
        logic [31:0] a_top;
        logic [31:0] top;
        logic [31:0] base;
        int          ct;
        int          cb;
        dec_res_t    res;
        c  = meta ^ NULL_MASK;
        ie = c[26];
        if (!ie)
        begin
            e     = 6'd0;
            tm    = {2'b00, c[25:17], c[16:14]};
            bm    = {c[13:3], c[2:0]};
            carry = tm[11:0] < bm[11:0];
        end
        else
        begin
            e     = {c[16:14], c[2:0]};
            tm    = {2'b00, c[25:17], 3'b000};
            bm    = {c[13:3], 3'b000};
            carry = c[25:17] < c[11:3];
        end
        top2  = bm[13:12] + {1'b0, carry} + {1'b0, ie};
        tm    = {top2, tm[11:0]};
        a3    = 3'(shr64(addr, int'(e) + 11));
        r     = bm[13:11] - 3'd1;
        ct    = region_shift(a3, tm[13:11], r);
        cb    = region_shift(a3, bm[13:11], r);
        a_top = 32'(shr64(addr, int'(e) + 14));
        top   = shl32(a_top + 32'(ct), int'(e) + 14) | shl32(32'(tm), int'(e));
        base  = shl32(a_top + 32'(cb), int'(e) + 14) | shl32(32'(bm), int'(e));
        res.base_off = base - addr[31:0];
        res.top_off  = top - addr[31:0];
        res.perm[PERM_READ]  = c[61];
        res.perm[PERM_WRITE] = c[60];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch on result %0d: %s", $time, results_checked, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        access_verdict_t want;
        dec_res_t        ent;
        longint          lo;
        longint          hi;
        logic            ok;
        if (!rst_n)
        begin
            verdict_q.delete();
            sticky_fault = 1'b0;
            outstanding <= 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (verdict_q.size() == 0)
                begin
                    report_mismatch("done strobe with no result outstanding");
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (base_offset !== want.base_off)
                        report_mismatch($sformatf("base_offset got %h want %h",
                                                  base_offset, want.base_off));
                    if (top_offset !== want.top_off)
                        report_mismatch($sformatf("top_offset got %h want %h",
                                                  top_offset, want.top_off));
                    if (can_read !== want.rd)
                        report_mismatch($sformatf("can_read got %b want %b", can_read, want.rd));
                    if (can_write !== want.wr)
                        report_mismatch($sformatf("can_write got %b want %b",
                                                  can_write, want.wr));
                    if (allowed !== want.ok)
                        report_mismatch($sformatf("allowed got %b want %b", allowed, want.ok));
                    if (fault_flag !== want.fault)
                        report_mismatch($sformatf("fault_flag got %b want %b",
                                                  fault_flag, want.fault));
                    results_checked++;
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                if (kind == KIND_LOAD)
                begin
                    ent = decode_cap(meta_word, address);
                    if (slot < CAP_SLOTS)
                        cap_table[slot] = ent;
                    ok = 1'b0;
                end
                else
                begin
                    ent = '0;
                    ok  = 1'b0;
                    if (slot < CAP_SLOTS)
                    begin
                        ent = cap_table[slot];
                        lo  = 4 * longint'(word_offset);
                        hi  = lo + longint'(access_bytes);
                        ok  = (longint'($signed(ent.base_off)) <= lo)
                              && (hi <= longint'($signed(ent.top_off)))
                              && (is_write ? ent.perm[PERM_WRITE] : ent.perm[PERM_READ]);
                    end
                    if (!ok)
                        sticky_fault = 1'b1;
                end
                want = '{ent.base_off, ent.top_off, ent.perm[PERM_READ], ent.perm[PERM_WRITE],
                         ok, sticky_fault};
                verdict_q.push_back(want);
            end
            outstanding <= verdict_q.size();
        end
    end

endmodule

// ===== dv/capability_bounds_decode_check_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the capability decoder: drives load and check beats and gives the verdict.
module capability_bounds_decode_check_tb;
    import cbdc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 200;
    localparam int PHASE_IDLE [0:3] = '{0, 61, 0, 37};

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic        kind         = 1'b0;
    logic [2:0]  slot         = 3'd0;
    logic [63:0] meta_word    = 64'd0;
    logic [63:0] address      = 64'd0;
    logic [15:0] word_offset  = 16'd0;
    logic [2:0]  access_bytes = 3'd0;
    logic        is_write     = 1'b0;
    logic        busy;
    logic        done;
    logic signed [31:0] base_offset;
    logic signed [31:0] top_offset;
    logic        can_read;
    logic        can_write;
    logic        allowed;
    logic        fault_flag;

    int          mismatches;
    int          outstanding;
    int          results_checked;
    int          cycles    = 0;
    int          idle_pct  = 0;
    int          sent      = 0;
    int          loads     = 0;
    int          checks    = 0;
    logic [7:0]  loaded    = 8'd0;

    always #5 clk = ~clk;

    capability_bounds_decode_check uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .slot         (slot),
        .meta_word    (meta_word),
        .address      (address),
        .word_offset  (word_offset),
        .access_bytes (access_bytes),
        .is_write     (is_write),
        .done         (done),
        .base_offset  (base_offset),
        .top_offset   (top_offset),
        .can_read     (can_read),
        .can_write    (can_write),
        .allowed      (allowed),
        .fault_flag   (fault_flag)
    );

    capability_bounds_decode_check_checker cap_watch (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .slot            (slot),
        .meta_word       (meta_word),
        .address         (address),
        .word_offset     (word_offset),
        .access_bytes    (access_bytes),
        .is_write        (is_write),
        .done            (done),
        .base_offset     (base_offset),
        .top_offset      (top_offset),
        .can_read        (can_read),
        .can_write       (can_write),
        .allowed         (allowed),
        .fault_flag      (fault_flag),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [63:0] pack_meta(input logic rd, input logic wr, input logic ie,
                                              input logic [8:0] t_hi, input logic [2:0] t_e,
                                              input logic [10:0] b_hi, input logic [2:0] b_e,
                                              input logic [63:0] fill);
        logic [63:0] c;
        c        = fill;
        c[61]    = rd;
        c[60]    = wr;
        c[26]    = ie;
        c[25:17] = t_hi;
        c[16:14] = t_e;
        c[13:3]  = b_hi;
        c[2:0]   = b_e;
        return c ^ NULL_MASK;
    endfunction

    function automatic logic [2:0] pick_slot();
        logic [2:0] s;
        s = 3'($urandom);
        while (!loaded[s])
            s = 3'($urandom);
        return s;
    endfunction

    task automatic issue(input logic k, input logic [2:0] s, input logic [63:0] meta,
                         input logic [63:0] addr, input logic [15:0] off,
                         input logic [2:0] nbytes, input logic wr_acc);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start        <= 1'b1;
        kind         <= k;
        slot         <= s;
        meta_word    <= meta;
        address      <= addr;
        word_offset  <= off;
        access_bytes <= nbytes;
        is_write     <= wr_acc;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sent++;
        if (k == KIND_LOAD)
            loads++;
        else
            checks++;
    endtask

    task automatic send_load(input logic [2:0] s, input logic [63:0] meta,
                             input logic [63:0] addr);
        issue(KIND_LOAD, s, meta, addr, 16'($urandom), 3'($urandom), 1'($urandom));
        loaded[s] = 1'b1;
    endtask

    task automatic send_check(input logic [2:0] s, input logic [15:0] off,
                              input logic [2:0] nbytes, input logic wr_acc);
        issue(KIND_CHECK, s, {$urandom, $urandom}, {$urandom, $urandom}, off, nbytes, wr_acc);
    endtask

    // place the address inside the decoded region so checks mostly hit it
    task automatic load_region(input logic [2:0] s, input int unsigned e, input logic rd,
                               input logic wr);
        logic [10:0] b_hi;
        logic [8:0]  t_hi;
        logic [63:0] mask;
        logic [63:0] addr;
        b_hi = 11'($urandom);
        t_hi = b_hi[8:0] + 9'($urandom_range(1, 200));
        mask = (64'd1 << (e + 14)) - 64'd1;
        addr = ({$urandom, $urandom} & ~mask) | (64'({b_hi, 3'b000}) << e);
        if ($urandom_range(3) == 0)
            addr = addr + 64'($urandom_range(1, 4 << e));
        send_load(s, pack_meta(rd, wr, 1'b1, t_hi, 3'(e >> 3), b_hi, 3'(e), {$urandom, $urandom}),
                  addr);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int          target;
        logic [2:0]  s;
        logic [2:0]  s2;
        logic [15:0] off;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_region(3'd0, 4, 1'b1, 1'b1);
        send_check(3'd0, 16'd0, 3'd0, 1'b0);
        send_check(3'd0, 16'd1, 3'd7, 1'b1);
        send_load(3'd1, NULL_MASK, 64'd0);
        send_load(3'd2, 64'd0, '1);
        send_load(3'd3, '1, '1);
        send_load(3'd4, pack_meta(1'b1, 1'b1, 1'b1, 9'h1FF, 3'd7, 11'h7FF, 3'd7, '0), '1);
        send_load(3'd5, pack_meta(1'b1, 1'b1, 1'b1, 9'h0A5, 3'd2, 11'h15A, 3'd2, '1),
                  64'h8000_0000_0000_0000);
        send_load(3'd6, pack_meta(1'b1, 1'b0, 1'b0, 9'h1FF, 3'd7, 11'h000, 3'd0, '0),
                  64'h0000_0000_7FFF_C000);
        send_load(3'd7, pack_meta(1'b0, 1'b1, 1'b1, 9'h010, 3'd0, 11'h7F0, 3'd3, '0),
                  {$urandom, $urandom});
        send_check(3'd6, 16'd0, 3'd4, 1'b1);
        send_check(3'd6, 16'd0, 3'd4, 1'b0);
        send_check(3'd7, 16'd0, 3'd4, 1'b0);
        send_check(3'd7, 16'hFFFF, 3'd7, 1'b1);
        send_check(3'd1, 16'd0, 3'd0, 1'b0);
        send_check(3'd3, 16'hFFFF, 3'd7, 1'b0);
        send_check(3'd4, 16'd0, 3'd0, 1'b1);
        send_check(3'd2, 16'h8000, 3'd4, 1'b0);
        load_region(3'd0, 0, 1'b1, 1'b1);
        send_check(3'd0, 16'd0, 3'd0, 1'b0);
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = PHASE_IDLE[ph];
            target   = sent + PHASE_ITEMS;
            while (sent < target)
            begin
                if ($urandom_range(99) < 75)
                begin
                    s = 3'($urandom);
                    load_region(s, $urandom_range(0, 8), $urandom_range(99) < 80,
                                $urandom_range(99) < 70);
                    repeat ($urandom_range(1, 6))
                    begin
                        s2  = ($urandom_range(99) < 70) ? s : pick_slot();
                        off = ($urandom_range(1) == 0) ? 16'($urandom_range(0, 1023))
                                                       : 16'($urandom);
                        send_check(s2, off, 3'($urandom), 1'($urandom));
                    end
                end
                else if ($urandom_range(1) == 0)
                begin
                    send_load(3'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
                end
                else
                begin
                    send_check(pick_slot(), 16'($urandom), 3'($urandom), 1'($urandom));
                end
                if (sent >= target - PHASE_ITEMS / 2 && sent < target - PHASE_ITEMS / 2 + 4)
                    drain_results();
            end
        end

        drain_results();
        repeat (8) @(posedge clk);

        $display("covered %0d capability loads and %0d access checks, %0d results compared",
                 loads, checks, results_checked);
        $display("pacing: back-to-back, sender idle 61 and 37 of 100, with full drains between");
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
